// File: sv/tomp_pkg.sv
// ----------------------------------------------------------------------------
// tomp_pkg: shared types and constants for the TCP option MSS parser
// Option kinds, parse phase codes, stop-cause codes and the state record.
// ----------------------------------------------------------------------------
`default_nettype none

package tomp_pkg;

    localparam int BYTE_W  = 8;
    localparam int MSS_W   = 16;
    localparam int CAUSE_W = 2;
    localparam int PHASE_W = 3;

    localparam logic [MSS_W-1:0] DEFAULT_MSS_RST = 16'd512;

    // option kinds
    localparam logic [BYTE_W-1:0] KIND_EOL = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NOP = 8'd1;
    localparam logic [BYTE_W-1:0] KIND_MSS = 8'd2;

    // option lengths
    localparam logic [BYTE_W-1:0] LEN_MIN     = 8'd2;
    localparam logic [BYTE_W-1:0] LEN_MSS_OPT = 8'd4;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_KIND = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd5;

    // stop causes
    localparam logic [CAUSE_W-1:0] CAUSE_OPTS_END = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_EOL      = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_UNKNOWN  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_BAD_LEN  = 2'd3;

    // parser state carried between items
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  skip_remaining;
        logic [BYTE_W-1:0]  mss_high_byte;
        logic [MSS_W-1:0]   mss_current;
        logic [CAUSE_W-1:0] cause_latched;
        logic               is_mss_option;
    } tomp_state_t;

    // one segment result
    typedef struct packed {
        logic [MSS_W-1:0]   mss_value;
        logic [CAUSE_W-1:0] stop_cause;
    } tomp_result_t;

endpackage

`default_nettype wire

// File: sv/tomp_ifs.sv
// ----------------------------------------------------------------------------
// tomp channel interfaces
// Valid/ready channels for option bytes, segment results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface tomp_in_if;
    import tomp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] opt_byte;
    logic              first_byte;
    logic              last_byte;
    logic              no_options;
    logic              syn_flag;

    modport source (
        output valid, opt_byte, first_byte, last_byte, no_options, syn_flag,
        input  ready
    );
    modport sink (
        input  valid, opt_byte, first_byte, last_byte, no_options, syn_flag,
        output ready
    );
endinterface

interface tomp_res_if;
    import tomp_pkg::*;
    logic               valid;
    logic               ready;
    logic [MSS_W-1:0]   mss_value;
    logic [CAUSE_W-1:0] stop_cause;

    modport source (
        output valid, mss_value, stop_cause,
        input  ready
    );
    modport sink (
        input  valid, mss_value, stop_cause,
        output ready
    );
endinterface

interface tomp_cfg_if;
    import tomp_pkg::*;
    logic             valid;
    logic             ready;
    logic [MSS_W-1:0] default_mss;

    modport source (
        output valid, default_mss,
        input  ready
    );
    modport sink (
        input  valid, default_mss,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/tcp_option_mss_parser_unit.sv
// A result is valid in the cycle after the item carrying last_byte or no_options
//   is accepted. Throughput: one option byte per cycle while no result waits
//   untaken; the parse state updates in one step per byte and the result
//   register frees input ready while it is taken.
// Reset: the parser returns to the start of a segment, default_mss to 512,
//   and no result is pending.
// ----------------------------------------------------------------------------
// tcp_option_mss_parser_unit: TCP option MSS parser
// Walks the option bytes of each segment and returns its MSS and stop cause.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_mss_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    tomp_in_if.sink   opt_in,
    tomp_res_if.source res_out,
    tomp_cfg_if.sink  cfg
);
    import tomp_pkg::*;

    tomp_state_t       state_reg;
    tomp_state_t       state_next;
    logic [MSS_W-1:0]  default_mss_reg;
    logic              res_valid_reg;
    tomp_result_t      res_reg;
    logic              core_fire;
    tomp_result_t      core_res;
    logic              in_accept;

    // input taken whenever the result register is free or being drained
    assign opt_in.ready = !res_valid_reg || res_out.ready;
    assign in_accept    = opt_in.valid && opt_in.ready;
    assign cfg.ready    = 1'b1;

    tomp_parse_core u_core (
        .state      (state_reg),
        .opt_byte   (opt_in.opt_byte),
        .first_byte (opt_in.first_byte),
        .last_byte  (opt_in.last_byte),
        .no_options (opt_in.no_options),
        .syn_flag   (opt_in.syn_flag),
        .default_mss(default_mss_reg),
        .state_next (state_next),
        .res_fire   (core_fire),
        .res        (core_res)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_mss_reg <= DEFAULT_MSS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            default_mss_reg <= cfg.default_mss;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase:          PH_KIND,
                           skip_remaining: 8'd0,
                           mss_high_byte:  8'd0,
                           mss_current:    DEFAULT_MSS_RST,
                           cause_latched:  CAUSE_OPTS_END,
                           is_mss_option:  1'b0};
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            res_valid_reg <= core_fire;
        end
        else if (res_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && core_fire)
        begin
            res_reg <= core_res;
        end
    end

    assign res_out.valid      = res_valid_reg;
    assign res_out.mss_value  = res_reg.mss_value;
    assign res_out.stop_cause = res_reg.stop_cause;

endmodule

`default_nettype wire

// File: sv/tomp_parse_core.sv
// ----------------------------------------------------------------------------
// tomp_parse_core: per-byte option parse step
// Computes the next parser state and the segment result for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tomp_parse_core (
    input  tomp_pkg::tomp_state_t  state,
    input  logic [7:0]             opt_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    input  logic                   no_options,
    input  logic                   syn_flag,
    input  logic [15:0]            default_mss,
    output tomp_pkg::tomp_state_t  state_next,
    output logic                   res_fire,
    output tomp_pkg::tomp_result_t res
);
    import tomp_pkg::*;

    tomp_state_t start_st;
    tomp_state_t cur_st;
    tomp_state_t step_st;

    // state at segment start
    always_comb
    begin
        start_st                = '0;
        start_st.phase          = PH_KIND;
        start_st.mss_current    = default_mss;
    end

    // one option byte through the phase machine
    always_comb
    begin
        cur_st  = first_byte ? start_st : state;
        step_st = cur_st;
        case (cur_st.phase)
            PH_KIND:
            begin
                if (opt_byte == KIND_EOL)
                begin
                    step_st.phase         = PH_DONE;
                    step_st.cause_latched = CAUSE_EOL;
                    step_st.is_mss_option = 1'b0;
                end
                else if (opt_byte == KIND_NOP)
                begin
                    step_st.phase = PH_KIND;
                end
                else if (opt_byte == KIND_MSS)
                begin
                    step_st.is_mss_option = 1'b1;
                    step_st.phase         = PH_LEN;
                end
                else
                begin
                    step_st.phase         = PH_DONE;
                    step_st.cause_latched = CAUSE_UNKNOWN;
                    step_st.is_mss_option = 1'b0;
                end
            end
            PH_LEN:
            begin
                if (opt_byte < LEN_MIN)
                begin
                    step_st.phase         = PH_DONE;
                    step_st.cause_latched = CAUSE_BAD_LEN;
                    step_st.is_mss_option = 1'b0;
                end
                else if (cur_st.is_mss_option && (opt_byte == LEN_MSS_OPT))
                begin
                    step_st.phase = PH_HIGH;
                end
                else
                begin
                    step_st.skip_remaining = opt_byte - LEN_MIN;
                    step_st.is_mss_option  = 1'b0;
                    step_st.phase          = (opt_byte == LEN_MIN) ? PH_KIND : PH_SKIP;
                end
            end
            PH_HIGH:
            begin
                step_st.mss_high_byte = opt_byte;
                step_st.phase         = PH_LOW;
            end
            PH_LOW:
            begin
                if (syn_flag)
                begin
                    step_st.mss_current = {cur_st.mss_high_byte, opt_byte};
                end
                step_st.is_mss_option = 1'b0;
                step_st.phase         = PH_KIND;
            end
            PH_SKIP:
            begin
                step_st.skip_remaining = cur_st.skip_remaining - 8'd1;
                if (cur_st.skip_remaining == 8'd1)
                begin
                    step_st.phase = PH_KIND;
                end
            end
            default:
            begin
                step_st = cur_st;
            end
        endcase
    end

    // result and state selection
    always_comb
    begin
        res_fire   = 1'b0;
        res        = '0;
        state_next = step_st;
        if (no_options)
        begin
            res_fire       = 1'b1;
            res.mss_value  = default_mss;
            res.stop_cause = CAUSE_OPTS_END;
            state_next     = start_st;
        end
        else if (last_byte)
        begin
            res_fire      = 1'b1;
            res.mss_value = step_st.mss_current;
            if (step_st.phase == PH_DONE)
            begin
                res.stop_cause = step_st.cause_latched;
            end
            else if (step_st.phase == PH_KIND)
            begin
                res.stop_cause = CAUSE_OPTS_END;
            end
            else
            begin
                res.stop_cause = CAUSE_BAD_LEN;
            end
            state_next = start_st;
        end
    end

endmodule

`default_nettype wire

// File: sv/tomp_checker.sv
// ----------------------------------------------------------------------------
// tomp_checker: port-level checks for the TCP option MSS parser
// Watches the channel handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tomp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        in_none,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_mss,
    input logic [1:0]  res_cause
);
    import tomp_pkg::*;

    // input stalls only behind an untaken result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (res_valid && !res_ready))
        else $error("input stalled without a blocked result");

    // a segment-ending item yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_last || in_none)) |=> res_valid)
        else $error("segment end gave no result");

    // an empty segment ends with the options-end cause
    a_empty_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_none) |=> (res_cause == CAUSE_OPTS_END))
        else $error("empty segment with wrong stop cause");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_mss) && $stable(res_cause)))
        else $error("stalled result changed");

endmodule

bind tcp_option_mss_parser_unit tomp_checker u_tomp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (opt_in.valid),
    .in_ready  (opt_in.ready),
    .in_last   (opt_in.last_byte),
    .in_none   (opt_in.no_options),
    .res_valid (res_out.valid),
    .res_ready (res_out.ready),
    .res_mss   (res_out.mss_value),
    .res_cause (res_out.stop_cause)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for tcp_option_mss_parser_unit
// Feeds TCP option bytes segment by segment over random handshakes, predicts
// each segment's MSS and stop cause, and compares every result in order.
// ----------------------------------------------------------------------------

module tb;
    import tomp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_ITEMS    = 165;
    localparam int DRAIN_CYCLES   = 4;

    // one option item plus an optional hand-written expectation
    typedef struct packed {
        logic [BYTE_W-1:0] opt_byte;
        logic              first;
        logic              last;
        logic              none;
        logic              syn;
        logic              typed;
        tomp_result_t      want;
    } opt_item_t;

    logic clk;
    logic rst_n;

    tomp_in_if  in_ch ();
    tomp_res_if res_ch ();
    tomp_cfg_if cfg_ch ();

    tcp_option_mss_parser_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .opt_in  (in_ch),
        .res_out (res_ch),
        .cfg     (cfg_ch)
    );

    // parser shadow and expected segment results
    tomp_state_t       parse_st;
    logic [MSS_W-1:0]  dflt_mss_model;
    tomp_result_t      mss_expect_q[$];
    tomp_result_t      mss_due;
    opt_item_t         seg_q[$];

    int fail_count;
    int stall_cycles;
    bit gaps_on;
    bit hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void start_segment();
        parse_st               = '0;
        parse_st.phase         = PH_KIND;
        parse_st.mss_current   = dflt_mss_model;
        parse_st.cause_latched = CAUSE_OPTS_END;
    endfunction

    function automatic void halt_parse(input logic [CAUSE_W-1:0] cause);
        parse_st.phase         = PH_DONE;
        parse_st.cause_latched = cause;
        parse_st.is_mss_option = 1'b0;
    endfunction

    // advances the shadow parser by one item; returns 1 when a segment closes
    function automatic bit predict_segment_mss(input opt_item_t it, output tomp_result_t r);
        logic [BYTE_W-1:0] b;
        b = it.opt_byte;
        r = '0;
        if (it.none)
        begin
            start_segment();
            r.mss_value  = dflt_mss_model;
            r.stop_cause = CAUSE_OPTS_END;
            return 1'b1;
        end
        if (it.first)
            start_segment();
        case (parse_st.phase)
            PH_KIND:
            begin
                if (b == KIND_EOL)
                    halt_parse(CAUSE_EOL);
                else if (b == KIND_MSS)
                begin
                    parse_st.is_mss_option = 1'b1;
                    parse_st.phase         = PH_LEN;
                end
                else if (b != KIND_NOP)
                    halt_parse(CAUSE_UNKNOWN);
            end
            PH_LEN:
            begin
                if (b < LEN_MIN)
                    halt_parse(CAUSE_BAD_LEN);
                else if (parse_st.is_mss_option && b == LEN_MSS_OPT)
                    parse_st.phase = PH_HIGH;
                else
                begin
                    parse_st.skip_remaining = b - LEN_MIN;
                    parse_st.is_mss_option  = 1'b0;
                    parse_st.phase = (parse_st.skip_remaining == 0) ? PH_KIND : PH_SKIP;
                end
            end
            PH_HIGH:
            begin
                parse_st.mss_high_byte = b;
                parse_st.phase         = PH_LOW;
            end
            PH_LOW:
            begin
                if (it.syn)
                    parse_st.mss_current = {parse_st.mss_high_byte, b};
                parse_st.is_mss_option = 1'b0;
                parse_st.phase         = PH_KIND;
            end
            PH_SKIP:
            begin
                parse_st.skip_remaining = parse_st.skip_remaining - 1'b1;
                if (parse_st.skip_remaining == 0)
                    parse_st.phase = PH_KIND;
            end
            default: ;
        endcase
        if (!it.last)
            return 1'b0;
        r.mss_value = parse_st.mss_current;
        if (parse_st.phase == PH_DONE)
            r.stop_cause = parse_st.cause_latched;
        else if (parse_st.phase == PH_KIND)
            r.stop_cause = CAUSE_OPTS_END;
        else
            r.stop_cause = CAUSE_BAD_LEN;
        start_segment();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] b, input bit first, input bit last,
                           input bit none, input bit syn, input bit typed,
                           input logic [MSS_W-1:0] mss, input logic [CAUSE_W-1:0] cause);
        opt_item_t it;
        it.opt_byte        = b;
        it.first           = first;
        it.last            = last;
        it.none            = none;
        it.syn             = syn;
        it.typed           = typed;
        it.want.mss_value  = mss;
        it.want.stop_cause = cause;
        seg_q.push_back(it);
    endtask

    // random segment: mostly well-formed option lists, some broken tails
    function automatic void gen_segment();
        logic [BYTE_W-1:0] bytes[$];
        opt_item_t it;
        int n_opts;
        int len;
        bit broken;
        bit syn;
        bit first_f;
        bit abandon;
        bit stopped;
        it = '0;
        if ($urandom_range(19) == 0)
        begin
            it.none     = 1'b1;
            it.opt_byte = BYTE_W'($urandom_range(255));
            it.first    = 1'($urandom_range(1));
            it.last     = 1'($urandom_range(1));
            it.syn      = 1'($urandom_range(1));
            seg_q.push_back(it);
            return;
        end
        broken  = ($urandom_range(4) == 0);
        stopped = 1'b0;
        n_opts  = $urandom_range(broken ? 2 : 4);
        for (int k = 0; k < n_opts && !stopped; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2: bytes.push_back(KIND_NOP);
                3, 4, 5, 6, 7:
                begin
                    bytes.push_back(KIND_MSS);
                    bytes.push_back(LEN_MSS_OPT);
                    bytes.push_back(BYTE_W'($urandom_range(255)));
                    bytes.push_back(BYTE_W'($urandom_range(255)));
                end
                8:
                begin
                    // mss option of another length, skipped by length
                    len = ($urandom_range(24) == 0) ? $urandom_range(9, 255)
                                                    : $urandom_range(2, 8);
                    if (len == LEN_MSS_OPT)
                        len = LEN_MSS_OPT - 1;
                    bytes.push_back(KIND_MSS);
                    bytes.push_back(BYTE_W'(len));
                    repeat (len - LEN_MIN) bytes.push_back(BYTE_W'($urandom_range(255)));
                end
                default:
                begin
                    // end of list followed by padding
                    bytes.push_back(KIND_EOL);
                    repeat ($urandom_range(3)) bytes.push_back(BYTE_W'($urandom_range(255)));
                    stopped = 1'b1;
                end
            endcase
        end
        if (broken)
        begin
            case ($urandom_range(3))
                0:
                begin
                    bytes.push_back(BYTE_W'($urandom_range(KIND_MSS + 1, 255)));
                    repeat ($urandom_range(3)) bytes.push_back(BYTE_W'($urandom_range(255)));
                end
                1:
                begin
                    bytes.push_back(KIND_MSS);
                    bytes.push_back(BYTE_W'($urandom_range(LEN_MIN - 1)));
                    repeat ($urandom_range(3)) bytes.push_back(BYTE_W'($urandom_range(255)));
                end
                2:
                begin
                    // option cut short by the end of the segment
                    bytes.push_back(KIND_MSS);
                    if ($urandom_range(2) != 0)
                    begin
                        len = $urandom_range(3, 8);
                        bytes.push_back(BYTE_W'(len));
                        repeat ($urandom_range(len - 3))
                            bytes.push_back(BYTE_W'($urandom_range(255)));
                    end
                end
                default:
                    repeat ($urandom_range(1, 6)) bytes.push_back(BYTE_W'($urandom_range(255)));
            endcase
        end
        if (bytes.size() == 0)
            bytes.push_back(KIND_NOP);
        syn     = ($urandom_range(3) != 0);
        first_f = ($urandom_range(9) != 0);
        abandon = ($urandom_range(19) == 0);
        for (int k = 0; k < bytes.size(); k++)
        begin
            it.opt_byte = bytes[k];
            it.first    = (k == 0) && first_f;
            it.last     = (k == bytes.size() - 1) && !abandon;
            it.syn      = syn;
            seg_q.push_back(it);
        end
    endfunction

    // offer one item, wait for the handshake, then predict
    task automatic send_item(input opt_item_t it);
        tomp_result_t r;
        while (gaps_on && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opt_byte   <= it.opt_byte;
        in_ch.first_byte <= it.first;
        in_ch.last_byte  <= it.last;
        in_ch.no_options <= it.none;
        in_ch.syn_flag   <= it.syn;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (predict_segment_mss(it, r))
            mss_expect_q.push_back(it.typed ? it.want : r);
    endtask

    task automatic send_queued();
        while (seg_q.size() != 0)
            send_item(seg_q.pop_front());
    endtask

    // sender pauses until every segment result is back, plus latency margin
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (mss_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_mss(input logic [MSS_W-1:0] v);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.default_mss <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid   <= 1'b0;
        dflt_mss_model  = v;
    endtask

    // result receiver with random stalls and a long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                res_ch.ready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (mss_expect_q.size() == 0)
                report_mismatch("result with none expected", res_ch.mss_value, 0);
            else
            begin
                mss_due = mss_expect_q.pop_front();
                if (res_ch.mss_value !== mss_due.mss_value)
                    report_mismatch("mss_value", res_ch.mss_value, mss_due.mss_value);
                if (res_ch.stop_cause !== mss_due.stop_cause)
                    report_mismatch("stop_cause", res_ch.stop_cause, mss_due.stop_cause);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // main sequence
    initial
    begin
        in_ch.valid        <= 1'b0;
        in_ch.opt_byte     <= '0;
        in_ch.first_byte   <= 1'b0;
        in_ch.last_byte    <= 1'b0;
        in_ch.no_options   <= 1'b0;
        in_ch.syn_flag     <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.default_mss <= '0;
        rst_n          = 1'b0;
        fail_count     = 0;
        stall_cycles   = 0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;
        dflt_mss_model = DEFAULT_MSS_RST;
        start_segment();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: byte, first, last, none, syn, typed, mss, cause
        // no options, other fields ignored
        add_row(8'hFF, 1, 1, 1, 1, 1, DEFAULT_MSS_RST, CAUSE_OPTS_END);
        // unfinished segment dropped by a new first byte
        add_row(KIND_MSS,    1, 0, 0, 1, 0, '0, '0);
        add_row(LEN_MSS_OPT, 0, 0, 0, 1, 0, '0, '0);
        add_row(8'h12,       0, 0, 0, 1, 0, '0, '0);
        // full mss option, largest value
        add_row(KIND_MSS,    1, 0, 0, 1, 0, '0, '0);
        add_row(LEN_MSS_OPT, 0, 0, 0, 1, 0, '0, '0);
        add_row(8'hFF,       0, 0, 0, 1, 0, '0, '0);
        add_row(8'hFF,       0, 1, 0, 1, 1, 16'hFFFF, CAUSE_OPTS_END);
        // end of list and unknown kind
        add_row(KIND_EOL, 1, 1, 0, 1, 1, DEFAULT_MSS_RST, CAUSE_EOL);
        add_row(8'hFF,    1, 1, 0, 1, 1, DEFAULT_MSS_RST, CAUSE_UNKNOWN);
        // length below two, trailing byte ignored
        add_row(KIND_MSS, 1, 0, 0, 1, 0, '0, '0);
        add_row(8'h00,    0, 0, 0, 1, 0, '0, '0);
        add_row(8'h08,    0, 1, 0, 1, 1, DEFAULT_MSS_RST, CAUSE_BAD_LEN);
        // segment ends inside the mss value
        add_row(KIND_MSS,    1, 0, 0, 1, 0, '0, '0);
        add_row(LEN_MSS_OPT, 0, 0, 0, 1, 0, '0, '0);
        add_row(8'hFF,       0, 1, 0, 1, 1, DEFAULT_MSS_RST, CAUSE_BAD_LEN);
        // nop then mss without syn keeps the default
        add_row(KIND_NOP,    1, 0, 0, 0, 0, '0, '0);
        add_row(KIND_MSS,    0, 0, 0, 0, 0, '0, '0);
        add_row(LEN_MSS_OPT, 0, 0, 0, 0, 0, '0, '0);
        add_row(8'h00,       0, 0, 0, 0, 0, '0, '0);
        add_row(8'h00,       0, 1, 0, 0, 1, DEFAULT_MSS_RST, CAUSE_OPTS_END);
        // mss option of length three, skipped
        add_row(KIND_MSS, 1, 0, 0, 1, 0, '0, '0);
        add_row(8'h03,    0, 0, 0, 1, 0, '0, '0);
        add_row(8'h77,    0, 1, 0, 1, 0, '0, '0);
        send_queued();
        drain();

        // random phases, one default_mss setting each
        for (int ph = 0; ph < 5; ph++)
        begin
            int n_sent;
            n_sent = 0;
            case (ph)
                0:       write_default_mss('0);
                1:       write_default_mss('1);
                default: write_default_mss(MSS_W'($urandom_range(16'hFFFF)));
            endcase
            gaps_on = (ph != 2);
            if (ph == 1 || ph == 3)
                hold_req = 1'b1;
            while (n_sent < PHASE_ITEMS)
            begin
                gen_segment();
                n_sent += seg_q.size();
                send_queued();
            end
            drain();
        end

        if (fail_count == 0 && mss_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
